[rtl/core/ffpa_pkg.sv]
// Shared types and constants of the first-fit partition allocator.
// Holds the table entry layout, status codes and sequencer states.
// No dependencies.
`default_nettype none

package ffpa_pkg;

  localparam int unsigned MemSize  = 1024;
  localparam int unsigned Entries  = 64;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned AddrW    = 10;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned SplitW   = 10;
  localparam logic [SplitW-1:0] SplitReset = SplitW'(10);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFit    = 2'd1,
    StNotFound = 2'd2,
    StZero     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FuncAlloc   = 1'b0,
    FuncRelease = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    SInit,
    SIdle,
    SScanRd,
    SScanChk,
    SNextRd,
    SNextChk,
    SRelPlan,
    SShRd,
    SShWr,
    SWr0,
    SWr1
  } state_e;

  typedef struct packed {
    logic             free;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] start;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/first_fit_partition_allocator.sv]
// First-fit partition allocator with coalescing of freed neighbours.
// Depends on ffpa_pkg for the entry layout, status codes and states.
//
// Usage: raise start_i with func_i, request_size_i and release_address_i
// while busy_o is low; the item is taken at that edge. Exactly one result
// follows: done_o is high for one cycle with granted_address_o and
// status_o, and the receiver cannot hold it off. busy_o stays high while
// an item is in work; a new item can be started in the cycle that shows
// the result.
// The partition table sits in one synchronous RAM (one read, one write
// per cycle, registered read data). Steps of one item: a zero-size
// allocate answers straight from idle; the scan reads and checks each
// entry up to the hit (or every entry on a miss); a release then reads
// the right neighbour, if any, and plans the merge; a split or merge
// shifts the table one entry at a time, a read and then a write, and
// ends with one or two entry writes. The scan and the shift through the
// one table RAM set the rate, and no new item is taken while one is in work.
// After reset the block writes entry zero as one free partition covering
// all memory; min_split_size resets to 10 and can be written through
// min_split_size_we_i at any edge while idle.
`default_nettype none

module first_fit_partition_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output      logic                            busy_o,
  input  wire logic                            func_i,
  input  wire logic [ffpa_pkg::SizeW-1:0]      request_size_i,
  input  wire logic [ffpa_pkg::AddrW-1:0]      release_address_i,
  input  wire logic                            min_split_size_we_i,
  input  wire logic [ffpa_pkg::SplitW-1:0]     min_split_size_i,
  output      logic                            done_o,
  output      logic [ffpa_pkg::AddrW-1:0]      granted_address_o,
  output      logic [1:0]                      status_o
);

  localparam int unsigned IdxW = ffpa_pkg::IdxW;
  localparam int unsigned CntW = ffpa_pkg::CntW;

  // Partition table RAM
  ffpa_pkg::entry_t mem_q [ffpa_pkg::Entries];
  ffpa_pkg::entry_t rdata_q;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;
  logic             wr_en;
  ffpa_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Control and work registers
  ffpa_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ffpa_pkg::SplitW-1:0] split_q;
  logic             done_q, done_d;
  logic [ffpa_pkg::AddrW-1:0] gaddr_q, gaddr_d;
  ffpa_pkg::status_e status_q, status_d;

  logic             func_q, func_d;
  logic [ffpa_pkg::SizeW-1:0] req_q, req_d;
  logic [ffpa_pkg::AddrW-1:0] rel_q, rel_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  ffpa_pkg::entry_t prev_q, prev_d;
  ffpa_pkg::entry_t hit_q, hit_d;
  ffpa_pkg::entry_t nxt_q, nxt_d;
  logic             nxt_ok_q, nxt_ok_d;
  logic [IdxW-1:0]  src_q, src_d;
  logic [IdxW-1:0]  dst_q, dst_d;
  logic [CntW-1:0]  nmov_q, nmov_d;
  logic             down_q, down_d;
  ffpa_pkg::entry_t fin0_q, fin0_d;
  ffpa_pkg::entry_t fin1_q, fin1_d;
  logic [IdxW-1:0]  widx_q, widx_d;
  logic             two_q, two_d;

  // Split threshold, zero acts as one
  logic [ffpa_pkg::SplitW-1:0] split_eff;
  assign split_eff = (split_q == '0) ? ffpa_pkg::SplitW'(1) : split_q;

  // Scan helpers
  logic [CntW-1:0]            idx_ext;
  logic                       last_entry;
  logic [ffpa_pkg::SizeW-1:0] rest;
  logic                       can_split;
  logic                       prev_free;
  logic                       next_free;
  logic [IdxW-1:0]            base;
  logic [CntW-1:0]            kill;
  logic [ffpa_pkg::SizeW-1:0] merged;

  assign idx_ext    = CntW'(idx_q);
  assign last_entry = (idx_ext + CntW'(1)) >= cnt_q;
  assign rest       = rdata_q.size - req_q;
  assign can_split  = (rest >= ffpa_pkg::SizeW'(split_eff)) &&
                      (cnt_q < CntW'(ffpa_pkg::Entries));
  assign prev_free  = (idx_q != '0) && prev_q.free;
  assign next_free  = nxt_ok_q && nxt_q.free;
  assign base       = prev_free ? (idx_q - IdxW'(1)) : idx_q;
  assign kill       = CntW'(prev_free) + CntW'(next_free);
  assign merged     = (prev_free ? prev_q.size : '0) + hit_q.size +
                      (next_free ? nxt_q.size : '0);

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffpa_pkg::SInit;
      cnt_q   <= CntW'(1);
      split_q <= ffpa_pkg::SplitReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (min_split_size_we_i) begin
        split_q <= min_split_size_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    gaddr_q  <= gaddr_d;
    status_q <= status_d;
    func_q   <= func_d;
    req_q    <= req_d;
    rel_q    <= rel_d;
    idx_q    <= idx_d;
    prev_q   <= prev_d;
    hit_q    <= hit_d;
    nxt_q    <= nxt_d;
    nxt_ok_q <= nxt_ok_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    nmov_q   <= nmov_d;
    down_q   <= down_d;
    fin0_q   <= fin0_d;
    fin1_q   <= fin1_d;
    widx_q   <= widx_d;
    two_q    <= two_d;
  end

  // Next state and RAM control
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    gaddr_d  = gaddr_q;
    status_d = status_q;
    func_d   = func_q;
    req_d    = req_q;
    rel_d    = rel_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    hit_d    = hit_q;
    nxt_d    = nxt_q;
    nxt_ok_d = nxt_ok_q;
    src_d    = src_q;
    dst_d    = dst_q;
    nmov_d   = nmov_q;
    down_d   = down_q;
    fin0_d   = fin0_q;
    fin1_d   = fin1_q;
    widx_d   = widx_q;
    two_d    = two_q;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = widx_q;
    wr_data  = fin0_q;

    case (state_q)
      ffpa_pkg::SInit: begin
        // Seed entry zero as one free partition
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data.free  = 1'b1;
        wr_data.size  = ffpa_pkg::SizeW'(ffpa_pkg::MemSize);
        wr_data.start = '0;
        state_d       = ffpa_pkg::SIdle;
      end
      ffpa_pkg::SIdle: begin
        if (start_i) begin
          func_d = func_i;
          req_d  = request_size_i;
          rel_d  = release_address_i;
          idx_d  = '0;
          if (func_i == ffpa_pkg::FuncAlloc && request_size_i == '0) begin
            done_d   = 1'b1;
            gaddr_d  = '0;
            status_d = ffpa_pkg::StZero;
          end else begin
            state_d = ffpa_pkg::SScanRd;
          end
        end
      end
      ffpa_pkg::SScanRd: begin
        rd_addr = idx_q;
        state_d = ffpa_pkg::SScanChk;
      end
      ffpa_pkg::SScanChk: begin
        if (func_q == ffpa_pkg::FuncAlloc) begin
          if (rdata_q.free && rdata_q.size >= req_q) begin
            // Grant, splitting off the remainder when it is large enough and the table has room
            fin0_d      = rdata_q;
            fin0_d.free = 1'b0;
            widx_d      = idx_q;
            gaddr_d     = rdata_q.start;
            status_d    = ffpa_pkg::StOk;
            if (can_split) begin
              fin0_d.size  = req_q;
              fin1_d.free  = 1'b1;
              fin1_d.size  = rest;
              fin1_d.start = rdata_q.start + ffpa_pkg::AddrW'(req_q);
              two_d        = 1'b1;
              src_d        = IdxW'(cnt_q - CntW'(1));
              dst_d        = IdxW'(cnt_q);
              down_d       = 1'b1;
              nmov_d       = cnt_q - idx_ext - CntW'(1);
              cnt_d        = cnt_q + CntW'(1);
              state_d      = (cnt_q - idx_ext - CntW'(1) == '0) ?
                             ffpa_pkg::SWr0 : ffpa_pkg::SShRd;
            end else begin
              two_d   = 1'b0;
              state_d = ffpa_pkg::SWr0;
            end
          end else if (last_entry) begin
            done_d   = 1'b1;
            gaddr_d  = '0;
            status_d = ffpa_pkg::StNoFit;
            state_d  = ffpa_pkg::SIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ffpa_pkg::SScanRd;
          end
        end else begin
          if (rdata_q.start == rel_q) begin
            hit_d = rdata_q;
            if (last_entry) begin
              nxt_ok_d = 1'b0;
              state_d  = ffpa_pkg::SRelPlan;
            end else begin
              state_d = ffpa_pkg::SNextRd;
            end
          end else if (last_entry) begin
            done_d   = 1'b1;
            gaddr_d  = '0;
            status_d = ffpa_pkg::StNotFound;
            state_d  = ffpa_pkg::SIdle;
          end else begin
            prev_d  = rdata_q;
            idx_d   = idx_q + IdxW'(1);
            state_d = ffpa_pkg::SScanRd;
          end
        end
      end
      ffpa_pkg::SNextRd: begin
        rd_addr = idx_q + IdxW'(1);
        state_d = ffpa_pkg::SNextChk;
      end
      ffpa_pkg::SNextChk: begin
        nxt_d    = rdata_q;
        nxt_ok_d = 1'b1;
        state_d  = ffpa_pkg::SRelPlan;
      end
      ffpa_pkg::SRelPlan: begin
        // Merge with free neighbours and close the gap behind the base;
        // skip the shift when nothing merges or no entries follow the gap
        fin0_d.free  = 1'b1;
        fin0_d.size  = merged;
        fin0_d.start = prev_free ? prev_q.start : hit_q.start;
        widx_d       = base;
        two_d        = 1'b0;
        gaddr_d      = '0;
        status_d     = ffpa_pkg::StOk;
        src_d        = IdxW'(CntW'(base) + CntW'(1) + kill);
        dst_d        = base + IdxW'(1);
        down_d       = 1'b0;
        nmov_d       = cnt_q - kill - CntW'(base) - CntW'(1);
        cnt_d        = cnt_q - kill;
        state_d      = (kill == '0 ||
                        cnt_q - kill - CntW'(base) - CntW'(1) == '0) ?
                       ffpa_pkg::SWr0 : ffpa_pkg::SShRd;
      end
      ffpa_pkg::SShRd: begin
        rd_addr = src_q;
        state_d = ffpa_pkg::SShWr;
      end
      ffpa_pkg::SShWr: begin
        // Move one entry, then advance both pointers
        wr_en   = 1'b1;
        wr_addr = dst_q;
        wr_data = rdata_q;
        nmov_d  = nmov_q - CntW'(1);
        src_d   = down_q ? src_q - IdxW'(1) : src_q + IdxW'(1);
        dst_d   = down_q ? dst_q - IdxW'(1) : dst_q + IdxW'(1);
        state_d = (nmov_q == CntW'(1)) ? ffpa_pkg::SWr0 : ffpa_pkg::SShRd;
      end
      ffpa_pkg::SWr0: begin
        wr_en   = 1'b1;
        wr_addr = widx_q;
        wr_data = fin0_q;
        if (two_q) begin
          state_d = ffpa_pkg::SWr1;
        end else begin
          done_d  = 1'b1;
          state_d = ffpa_pkg::SIdle;
        end
      end
      ffpa_pkg::SWr1: begin
        wr_en   = 1'b1;
        wr_addr = widx_q + IdxW'(1);
        wr_data = fin1_q;
        done_d  = 1'b1;
        state_d = ffpa_pkg::SIdle;
      end
      default: begin
        state_d = ffpa_pkg::SIdle;
      end
    endcase
  end

  assign busy_o            = (state_q != ffpa_pkg::SIdle);
  assign done_o            = done_q;
  assign granted_address_o = gaddr_q;
  assign status_o          = status_q;

endmodule

`default_nettype wire
